// ===== hw/rtl/qlt_pkg.sv =====
// Shared constants, types and keyword lookup for the query tokenizer.
`default_nettype none
package qlt_pkg;

    localparam int POS_W_DEFAULT = 16;
    localparam int MAX_RESULTS   = 10;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int HOLD_DEPTH    = 7;
    localparam int NUM_KW        = 23;

    // Result kinds.
    localparam logic [1:0] RK_VALUE = 2'd0;
    localparam logic [1:0] RK_TOKEN = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_BAD_CHAR    = 3'd0;
    localparam logic [2:0] ERR_LONE_BANG   = 3'd1;
    localparam logic [2:0] ERR_BAD_ESCAPE  = 3'd2;
    localparam logic [2:0] ERR_OPEN_STRING = 3'd3;
    localparam logic [2:0] ERR_OPEN_ESCAPE = 3'd4;
    localparam logic [2:0] ERR_NONE        = 3'd0;

    // Token types.
    localparam logic [5:0] T_NONE      = 6'd0;
    localparam logic [5:0] T_IDENT     = 6'd23;
    localparam logic [5:0] T_DDOT      = 6'd24;
    localparam logic [5:0] T_DOT       = 6'd25;
    localparam logic [5:0] T_LBRACKET  = 6'd26;
    localparam logic [5:0] T_RBRACKET  = 6'd27;
    localparam logic [5:0] T_LBRACE    = 6'd28;
    localparam logic [5:0] T_RBRACE    = 6'd29;
    localparam logic [5:0] T_LPAREN    = 6'd30;
    localparam logic [5:0] T_RPAREN    = 6'd31;
    localparam logic [5:0] T_UPD_ASSIGN = 6'd32;
    localparam logic [5:0] T_PIPE      = 6'd33;
    localparam logic [5:0] T_COLON     = 6'd34;
    localparam logic [5:0] T_SEMI      = 6'd35;
    localparam logic [5:0] T_COMMA     = 6'd36;
    localparam logic [5:0] T_QUESTION  = 6'd37;
    localparam logic [5:0] T_PLUS_ASSIGN = 6'd38;
    localparam logic [5:0] T_PLUS      = 6'd39;
    localparam logic [5:0] T_STAR_ASSIGN = 6'd40;
    localparam logic [5:0] T_STAR      = 6'd41;
    localparam logic [5:0] T_PERCENT   = 6'd42;
    localparam logic [5:0] T_ALT_ASSIGN = 6'd43;
    localparam logic [5:0] T_ALT       = 6'd44;
    localparam logic [5:0] T_SLASH_ASSIGN = 6'd45;
    localparam logic [5:0] T_SLASH     = 6'd46;
    localparam logic [5:0] T_EQUAL     = 6'd47;
    localparam logic [5:0] T_ASSIGN    = 6'd48;
    localparam logic [5:0] T_NOT_EQUAL = 6'd49;
    localparam logic [5:0] T_LESS_EQ   = 6'd50;
    localparam logic [5:0] T_LESS      = 6'd51;
    localparam logic [5:0] T_GREATER_EQ = 6'd52;
    localparam logic [5:0] T_GREATER   = 6'd53;
    localparam logic [5:0] T_MINUS_ASSIGN = 6'd54;
    localparam logic [5:0] T_NUMBER    = 6'd55;
    localparam logic [5:0] T_MINUS     = 6'd56;
    localparam logic [5:0] T_STRING    = 6'd57;
    localparam logic [5:0] T_EOF       = 6'd58;

    typedef struct packed {
        logic       hit;
        logic [5:0] idx;
    } kw_hit_t;

    function automatic logic [55:0] kw_text(input logic [4:0] k);
        logic [55:0] t;
        unique case (k)
            5'd0:  t = 56'("true");
            5'd1:  t = 56'("false");
            5'd2:  t = 56'("null");
            5'd3:  t = 56'("and");
            5'd4:  t = 56'("or");
            5'd5:  t = 56'("not");
            5'd6:  t = 56'("if");
            5'd7:  t = 56'("then");
            5'd8:  t = 56'("else");
            5'd9:  t = 56'("elif");
            5'd10: t = 56'("end");
            5'd11: t = 56'("as");
            5'd12: t = 56'("def");
            5'd13: t = 56'("try");
            5'd14: t = 56'("catch");
            5'd15: t = 56'("reduce");
            5'd16: t = 56'("foreach");
            5'd17: t = 56'("while");
            5'd18: t = 56'("until");
            5'd19: t = 56'("select");
            5'd20: t = 56'("map");
            5'd21: t = 56'("empty");
            5'd22: t = 56'("error");
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [4:0] k);
        logic [2:0] l;
        unique case (k)
            5'd4, 5'd6, 5'd11: l = 3'd2;
            5'd3, 5'd5, 5'd10, 5'd12, 5'd13, 5'd20: l = 3'd3;
            5'd0, 5'd2, 5'd7, 5'd8, 5'd9: l = 3'd4;
            5'd1, 5'd14, 5'd17, 5'd18, 5'd21, 5'd22: l = 3'd5;
            5'd15, 5'd19: l = 3'd6;
            5'd16: l = 3'd7;
            default: l = 3'd0;
        endcase
        return l;
    endfunction

    // Exact match of the held identifier bytes against the keyword list.
    function automatic kw_hit_t kw_lookup(input logic [HOLD_DEPTH-1:0][7:0] kb,
                                          input logic [2:0] cnt);
        kw_hit_t     r;
        logic [55:0] txt;
        logic [2:0]  len;
        logic        m;
        logic [2:0]  pos;
        r = '0;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            txt = kw_text(5'(k));
            len = kw_len(5'(k));
            m   = (len == cnt);
            for (int j = 0; j < HOLD_DEPTH; j++) begin
                pos = (3'(j) < len) ? (len - 3'd1 - 3'(j)) : 3'd0;
                if ((3'(j) < len) && (kb[j] != txt[8*pos +: 8])) begin
                    m = 1'b0;
                end
            end
            if (m) begin
                r.hit = 1'b1;
                r.idx = 6'(k);
            end
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == " ");
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/qlt_scan.sv =====
// Scanner state and the multi-pass combinational logic that turns one byte or end marker into results.
`default_nettype none
module qlt_scan
    import qlt_pkg::*;
#(
    parameter int PW = POS_W_DEFAULT,
    parameter int EW = PW + 19
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  accept_i,
    input  wire logic                                  kind_i,
    input  wire logic [7:0]                            byte_i,
    output logic      [MAX_RESULTS-1:0][EW-1:0]        list_o,
    output logic      [CNT_W-1:0]                      count_o
);

    typedef enum logic [20:0] {
        M_IDLE   = 21'd1 << 0,
        M_IDENT  = 21'd1 << 1,
        M_INT    = 21'd1 << 2,
        M_NDOT   = 21'd1 << 3,
        M_FRAC   = 21'd1 << 4,
        M_EXP0   = 21'd1 << 5,
        M_EXPD   = 21'd1 << 6,
        M_STR    = 21'd1 << 7,
        M_ESC    = 21'd1 << 8,
        M_DOT    = 21'd1 << 9,
        M_PIPE   = 21'd1 << 10,
        M_PLUS   = 21'd1 << 11,
        M_STAR   = 21'd1 << 12,
        M_SLASH  = 21'd1 << 13,
        M_SLASH2 = 21'd1 << 14,
        M_EQ     = 21'd1 << 15,
        M_BANG   = 21'd1 << 16,
        M_LT     = 21'd1 << 17,
        M_GT     = 21'd1 << 18,
        M_MINUS  = 21'd1 << 19,
        M_DROP   = 21'd1 << 20
    } mode_t;

    typedef struct packed {
        logic [1:0]    kind;
        logic [5:0]    ttype;
        logic [7:0]    val;
        logic [2:0]    err;
        logic [PW-1:0] pos;
    } entry_t;

    mode_t                         mode_reg, mode_next;
    logic [HOLD_DEPTH-1:0][7:0]    kbuf_reg, kbuf_next;
    logic [2:0]                    bcount_reg, bcount_next;
    logic                          ovf_reg, ovf_next;
    logic [PW-1:0]                 pos_reg, pos_next;
    logic [PW-1:0]                 tstart_reg, tstart_next;
    logic [PW-1:0]                 dstart_reg, dstart_next;

    entry_t                        lst [MAX_RESULTS];
    logic [CNT_W-1:0]              n;

    function automatic entry_t mk(input logic [1:0] k, input logic [5:0] t,
                                  input logic [7:0] v, input logic [PW-1:0] p,
                                  input logic [2:0] e);
        entry_t r;
        r.kind  = k;
        r.ttype = t;
        r.val   = v;
        r.err   = e;
        r.pos   = p;
        return r;
    endfunction

    function automatic void push(inout entry_t l [MAX_RESULTS],
                                 inout logic [CNT_W-1:0] cnt, input entry_t e);
        if (cnt < CNT_W'(MAX_RESULTS)) begin
            l[cnt] = e;
            cnt    = cnt + 1'b1;
        end
    endfunction

    always_comb begin
        mode_t         m;
        logic          done;
        logic          at_end;
        logic [7:0]    c;
        logic [PW-1:0] cur;
        logic [7:0]    sec;
        logic [5:0]    pair_t;
        logic [5:0]    single_t;
        logic [7:0]    d;
        logic          d_ok;
        kw_hit_t       kw;

        m           = mode_reg;
        kbuf_next   = kbuf_reg;
        bcount_next = bcount_reg;
        ovf_next    = ovf_reg;
        tstart_next = tstart_reg;
        dstart_next = dstart_reg;
        at_end      = kind_i;
        c           = at_end ? 8'd0 : byte_i;
        cur         = pos_reg;
        n           = '0;
        done        = 1'b0;
        sec         = "=";
        pair_t      = T_NONE;
        single_t    = T_NONE;
        d           = 8'd0;
        d_ok        = 1'b0;
        kw          = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            lst[i] = '0;
        end

        // At most three passes: number dot -> dot -> idle.
        for (int p = 0; p < 3; p++) begin
            if (!done) begin
                done = 1'b1;
                unique case (m)
                    M_IDLE: begin
                        if (at_end) begin
                            push(lst, n, mk(RK_TOKEN, T_EOF, 8'd0, cur, ERR_NONE));
                        end else if (!is_space(c)) begin
                            tstart_next = cur;
                            unique case (c)
                                "[": push(lst, n, mk(RK_TOKEN, T_LBRACKET, 8'd0, cur, ERR_NONE));
                                "]": push(lst, n, mk(RK_TOKEN, T_RBRACKET, 8'd0, cur, ERR_NONE));
                                "{": push(lst, n, mk(RK_TOKEN, T_LBRACE, 8'd0, cur, ERR_NONE));
                                "}": push(lst, n, mk(RK_TOKEN, T_RBRACE, 8'd0, cur, ERR_NONE));
                                "(": push(lst, n, mk(RK_TOKEN, T_LPAREN, 8'd0, cur, ERR_NONE));
                                ")": push(lst, n, mk(RK_TOKEN, T_RPAREN, 8'd0, cur, ERR_NONE));
                                ":": push(lst, n, mk(RK_TOKEN, T_COLON, 8'd0, cur, ERR_NONE));
                                ";": push(lst, n, mk(RK_TOKEN, T_SEMI, 8'd0, cur, ERR_NONE));
                                ",": push(lst, n, mk(RK_TOKEN, T_COMMA, 8'd0, cur, ERR_NONE));
                                "?": push(lst, n, mk(RK_TOKEN, T_QUESTION, 8'd0, cur, ERR_NONE));
                                "%": push(lst, n, mk(RK_TOKEN, T_PERCENT, 8'd0, cur, ERR_NONE));
                                ".": m = M_DOT;
                                "|": m = M_PIPE;
                                "+": m = M_PLUS;
                                "*": m = M_STAR;
                                "/": m = M_SLASH;
                                "=": m = M_EQ;
                                "!": m = M_BANG;
                                "<": m = M_LT;
                                ">": m = M_GT;
                                "-": m = M_MINUS;
                                "\"": m = M_STR;
                                default: begin
                                    if (is_alpha(c) || (c == "_")) begin
                                        kbuf_next[0] = c;
                                        bcount_next  = 3'd1;
                                        ovf_next     = 1'b0;
                                        m            = M_IDENT;
                                    end else if (is_digit(c)) begin
                                        push(lst, n, mk(RK_VALUE, T_NUMBER, c, cur, ERR_NONE));
                                        m = M_INT;
                                    end else begin
                                        push(lst, n, mk(RK_ERROR, T_NONE, 8'd0, cur,
                                                        ERR_BAD_CHAR));
                                        m = M_DROP;
                                    end
                                end
                            endcase
                        end
                    end
                    M_DROP: ;
                    M_DOT, M_PIPE, M_PLUS, M_STAR, M_SLASH2, M_EQ, M_LT, M_GT: begin
                        sec = (m == M_DOT) ? "." : "=";
                        unique case (m)
                            M_DOT:    begin pair_t = T_DDOT;         single_t = T_DOT;      end
                            M_PIPE:   begin pair_t = T_UPD_ASSIGN;   single_t = T_PIPE;     end
                            M_PLUS:   begin pair_t = T_PLUS_ASSIGN;  single_t = T_PLUS;     end
                            M_STAR:   begin pair_t = T_STAR_ASSIGN;  single_t = T_STAR;     end
                            M_SLASH2: begin pair_t = T_ALT_ASSIGN;   single_t = T_ALT;      end
                            M_EQ:     begin pair_t = T_EQUAL;        single_t = T_ASSIGN;   end
                            M_LT:     begin pair_t = T_LESS_EQ;      single_t = T_LESS;     end
                            default:  begin pair_t = T_GREATER_EQ;   single_t = T_GREATER;  end
                        endcase
                        if (!at_end && (c == sec)) begin
                            push(lst, n, mk(RK_TOKEN, pair_t, 8'd0, tstart_next, ERR_NONE));
                            m = M_IDLE;
                        end else begin
                            push(lst, n, mk(RK_TOKEN, single_t, 8'd0, tstart_next, ERR_NONE));
                            m    = M_IDLE;
                            done = 1'b0;
                        end
                    end
                    M_IDENT: begin
                        if (!at_end && (is_alpha(c) || is_digit(c) || (c == "_"))) begin
                            if (ovf_next) begin
                                push(lst, n, mk(RK_VALUE, T_IDENT, c, tstart_next, ERR_NONE));
                            end else if (bcount_next < 3'(HOLD_DEPTH)) begin
                                kbuf_next[bcount_next] = c;
                                bcount_next = bcount_next + 3'd1;
                            end else begin
                                for (int i = 0; i < HOLD_DEPTH; i++) begin
                                    push(lst, n, mk(RK_VALUE, T_IDENT, kbuf_next[i],
                                                    tstart_next, ERR_NONE));
                                end
                                push(lst, n, mk(RK_VALUE, T_IDENT, c, tstart_next, ERR_NONE));
                                ovf_next    = 1'b1;
                                bcount_next = 3'd0;
                            end
                        end else begin
                            kw = kw_lookup(kbuf_next, bcount_next);
                            if (!ovf_next && kw.hit) begin
                                push(lst, n, mk(RK_TOKEN, kw.idx, 8'd0, tstart_next,
                                                ERR_NONE));
                            end else begin
                                if (!ovf_next) begin
                                    for (int i = 0; i < HOLD_DEPTH; i++) begin
                                        if (3'(i) < bcount_next) begin
                                            push(lst, n, mk(RK_VALUE, T_IDENT, kbuf_next[i],
                                                            tstart_next, ERR_NONE));
                                        end
                                    end
                                end
                                push(lst, n, mk(RK_TOKEN, T_IDENT, 8'd0, tstart_next,
                                                ERR_NONE));
                            end
                            bcount_next = 3'd0;
                            ovf_next    = 1'b0;
                            m           = M_IDLE;
                            done        = 1'b0;
                        end
                    end
                    M_INT, M_FRAC, M_EXPD: begin
                        if (!at_end && is_digit(c)) begin
                            push(lst, n, mk(RK_VALUE, T_NUMBER, c, tstart_next, ERR_NONE));
                        end else if (!at_end && (m != M_EXPD) && ((c == "e") || (c == "E")))
                        begin
                            push(lst, n, mk(RK_VALUE, T_NUMBER, c, tstart_next, ERR_NONE));
                            m = M_EXP0;
                        end else if (!at_end && (m == M_INT) && (c == ".")) begin
                            dstart_next = cur;
                            m = M_NDOT;
                        end else begin
                            push(lst, n, mk(RK_TOKEN, T_NUMBER, 8'd0, tstart_next, ERR_NONE));
                            m    = M_IDLE;
                            done = 1'b0;
                        end
                    end
                    M_EXP0: begin
                        if (!at_end && (is_digit(c) || (c == "+") || (c == "-"))) begin
                            push(lst, n, mk(RK_VALUE, T_NUMBER, c, tstart_next, ERR_NONE));
                            m = M_EXPD;
                        end else begin
                            push(lst, n, mk(RK_TOKEN, T_NUMBER, 8'd0, tstart_next, ERR_NONE));
                            m    = M_IDLE;
                            done = 1'b0;
                        end
                    end
                    M_NDOT: begin
                        if (!at_end && is_digit(c)) begin
                            push(lst, n, mk(RK_VALUE, T_NUMBER, ".", tstart_next, ERR_NONE));
                            push(lst, n, mk(RK_VALUE, T_NUMBER, c, tstart_next, ERR_NONE));
                            m = M_FRAC;
                        end else begin
                            push(lst, n, mk(RK_TOKEN, T_NUMBER, 8'd0, tstart_next, ERR_NONE));
                            tstart_next = dstart_next;
                            m    = M_DOT;
                            done = 1'b0;
                        end
                    end
                    M_STR: begin
                        if (at_end) begin
                            push(lst, n, mk(RK_ERROR, T_NONE, 8'd0, tstart_next,
                                            ERR_OPEN_STRING));
                            m = M_DROP;
                        end else if (c == "\"") begin
                            push(lst, n, mk(RK_TOKEN, T_STRING, 8'd0, tstart_next, ERR_NONE));
                            m = M_IDLE;
                        end else if (c == "\\") begin
                            m = M_ESC;
                        end else begin
                            push(lst, n, mk(RK_VALUE, T_STRING, c, tstart_next, ERR_NONE));
                        end
                    end
                    M_ESC: begin
                        d_ok = 1'b1;
                        unique case (c)
                            "n":  d = 8'd10;
                            "t":  d = 8'd9;
                            "r":  d = 8'd13;
                            "\\": d = "\\";
                            "\"": d = "\"";
                            "/":  d = "/";
                            default: d_ok = 1'b0;
                        endcase
                        if (at_end) begin
                            push(lst, n, mk(RK_ERROR, T_NONE, 8'd0, tstart_next,
                                            ERR_OPEN_ESCAPE));
                            m = M_DROP;
                        end else if (!d_ok) begin
                            push(lst, n, mk(RK_ERROR, T_NONE, 8'd0, tstart_next,
                                            ERR_BAD_ESCAPE));
                            m = M_DROP;
                        end else begin
                            push(lst, n, mk(RK_VALUE, T_STRING, d, tstart_next, ERR_NONE));
                            m = M_STR;
                        end
                    end
                    M_SLASH: begin
                        if (!at_end && (c == "/")) begin
                            m = M_SLASH2;
                        end else if (!at_end && (c == "=")) begin
                            push(lst, n, mk(RK_TOKEN, T_SLASH_ASSIGN, 8'd0, tstart_next,
                                            ERR_NONE));
                            m = M_IDLE;
                        end else begin
                            push(lst, n, mk(RK_TOKEN, T_SLASH, 8'd0, tstart_next, ERR_NONE));
                            m    = M_IDLE;
                            done = 1'b0;
                        end
                    end
                    M_BANG: begin
                        if (!at_end && (c == "=")) begin
                            push(lst, n, mk(RK_TOKEN, T_NOT_EQUAL, 8'd0, tstart_next,
                                            ERR_NONE));
                            m = M_IDLE;
                        end else begin
                            push(lst, n, mk(RK_ERROR, T_NONE, 8'd0, tstart_next,
                                            ERR_LONE_BANG));
                            m = M_DROP;
                        end
                    end
                    M_MINUS: begin
                        if (!at_end && (c == "=")) begin
                            push(lst, n, mk(RK_TOKEN, T_MINUS_ASSIGN, 8'd0, tstart_next,
                                            ERR_NONE));
                            m = M_IDLE;
                        end else if (!at_end && is_digit(c)) begin
                            push(lst, n, mk(RK_VALUE, T_NUMBER, "-", tstart_next, ERR_NONE));
                            push(lst, n, mk(RK_VALUE, T_NUMBER, c, tstart_next, ERR_NONE));
                            m = M_INT;
                        end else begin
                            push(lst, n, mk(RK_TOKEN, T_MINUS, 8'd0, tstart_next, ERR_NONE));
                            m    = M_IDLE;
                            done = 1'b0;
                        end
                    end
                    default: begin
                        m    = M_IDLE;
                        done = 1'b0;
                    end
                endcase
            end
        end

        mode_next = m;
        pos_next  = (cur == '1) ? cur : cur + 1'b1;
        // The end marker returns everything to the reset picture.
        if (at_end) begin
            mode_next   = M_IDLE;
            bcount_next = 3'd0;
            ovf_next    = 1'b0;
            pos_next    = '0;
            tstart_next = '0;
            dstart_next = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            list_o[i] = lst[i];
        end
        count_o = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            bcount_reg <= 3'd0;
            ovf_reg    <= 1'b0;
            pos_reg    <= '0;
            tstart_reg <= '0;
            dstart_reg <= '0;
        end else if (accept_i) begin
            mode_reg   <= mode_next;
            bcount_reg <= bcount_next;
            ovf_reg    <= ovf_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            dstart_reg <= dstart_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_i) begin
            kbuf_reg <= kbuf_next;
        end
    end

`ifndef SYNTH
    a_hold_count: assert property (@(posedge aclk) disable iff (!aresetn)
        bcount_reg <= 3'(HOLD_DEPTH))
        else $error("held identifier count beyond buffer depth");
    a_ovf_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (bcount_reg == 3'd0))
        else $error("overflowed identifier still holds bytes");
    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_i && kind_i) |=> (mode_reg == M_IDLE) && (pos_reg == '0))
        else $error("end marker did not restart the scanner");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/qlt_burst.sv =====
// Result register: holds the results of one request and hands them out in order.
`default_nettype none
module qlt_burst #(
    parameter int DEPTH  = 10,
    parameter int DATA_W = 35
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  load_i,
    input  wire logic [DEPTH-1:0][DATA_W-1:0]          data_i,
    input  wire logic [$clog2(DEPTH+1)-1:0]            count_i,
    output logic                                       can_load_o,
    output logic                                       valid_o,
    input  wire logic                                  ready_i,
    output logic      [DATA_W-1:0]                     data_o,
    output logic                                       last_o
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][DATA_W-1:0] q_reg;
    logic [DEPTH-1:0]             last_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         pop;

    assign valid_o    = (cnt_reg != '0);
    assign pop        = valid_o && ready_i;
    assign can_load_o = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && ready_i);
    assign data_o     = q_reg[0];
    assign last_o     = last_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load_i) begin
            cnt_reg <= count_i;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            q_reg <= data_i;
            for (int i = 0; i < DEPTH; i++) begin
                last_reg[i] <= (CW'(i) == (count_i - 1'b1));
            end
        end else if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                q_reg[i]    <= q_reg[i+1];
                last_reg[i] <= last_reg[i+1];
            end
        end
    end

`ifndef SYNTH
    a_load_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i |-> ((cnt_reg == '0) || ((cnt_reg == CW'(1)) && pop)))
        else $error("results overwritten before delivery");
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("result count beyond depth");
    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_o |-> (last_o == (cnt_reg == CW'(1))))
        else $error("last flag out of step with result count");
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_i && (count_i != '0)) |=> valid_o)
        else $error("loaded results not presented");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/query_language_tokenizer_core.sv =====
// Top level of the streaming query tokenizer.
//
// Requests arrive on the s_ channel, one query byte each (s_kind = 0) or an
// end of query marker (s_kind = 1); results leave on the m_ channel as value
// bytes, finished tokens or errors, with m_last set on the final result of
// each request. Both channels use valid/ready.
// A request is scanned in the cycle it is accepted: the scanner state updates
// at that edge and all of its results (zero to ten) are written into the
// result register at once. The first result appears on m_ in the next cycle,
// and the results then leave one per cycle while m_ready is high.
// Throughput is one request per cycle while each request yields at most one
// result and m_ready is high; a request with k results holds s_ready low until
// its last result is leaving, since the result register takes a new request
// only when it is empty or its last entry is leaving. A request yielding no
// result leaves the result register empty, so s_ready stays high. When the
// receiver stalls, results stay in the result register and s_ready drops once
// the last entry cannot leave. Synchronous reset clears the scan state, the
// position counter and the result register; no initialization sequence
// follows. After an end marker the scanner starts over at position zero.
`default_nettype none
module query_language_tokenizer_core
    import qlt_pkg::*;
#(
    parameter int POSITION_WIDTH = POS_W_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [7:0]                    s_text_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [1:0]                    m_result_kind,
    output logic      [5:0]                    m_token_type,
    output logic      [7:0]                    m_value_byte,
    output logic      [POSITION_WIDTH-1:0]     m_start_position,
    output logic      [2:0]                    m_error_code,
    output logic                               m_last
);

    // Entry layout, high to low: kind, type, value, error, position.
    localparam int PW = POSITION_WIDTH;
    localparam int EW = PW + 19;

    logic                           accept;
    logic [MAX_RESULTS-1:0][EW-1:0] list;
    logic [CNT_W-1:0]               count;
    logic [EW-1:0]                  head;

    assign accept = s_valid && s_ready;

    qlt_scan #(
        .PW (PW),
        .EW (EW)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept_i (accept),
        .kind_i   (s_kind),
        .byte_i   (s_text_byte),
        .list_o   (list),
        .count_o  (count)
    );

    qlt_burst #(
        .DEPTH  (MAX_RESULTS),
        .DATA_W (EW)
    ) u_burst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_i     (accept),
        .data_i     (list),
        .count_i    (count),
        .can_load_o (s_ready),
        .valid_o    (m_valid),
        .ready_i    (m_ready),
        .data_o     (head),
        .last_o     (m_last)
    );

    assign m_start_position = head[PW-1:0];
    assign m_error_code     = head[PW+2:PW];
    assign m_value_byte     = head[PW+10:PW+3];
    assign m_token_type     = head[PW+16:PW+11];
    assign m_result_kind    = head[PW+18:PW+17];

endmodule
`default_nettype wire
